// ----- hw/rtl/sactl_pkg.sv -----
// Package for the set-associative cache tag store with LRU replacement.
// Holds sizes, codes, the transaction structs and the state machine type.
// No dependencies; every other file in hw/rtl imports it.
package sactl_pkg;

   localparam int MAX_SET_BITS = 6;
   localparam int MAX_WAYS     = 4;
   localparam int NUM_SETS     = 1 << MAX_SET_BITS;
   localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int ADDR_W       = 64;
   localparam int TAG_W        = 64;
   localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int AGE_W        = WAY_W;
   localparam int NW_W         = $clog2(MAX_WAYS + 1);
   localparam int CNT_W        = 32;

   localparam int SETB_W     = 3;
   localparam int WAYS_W     = 3;
   localparam int BLKB_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

   // Access kinds.
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OP_IFETCH = 2'd3;

   // Lookup outcomes.
   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_MISS  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_LOOKUP2
   } state_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]       outcome;
      logic [CNT_W-1:0] hit_total;
      logic [CNT_W-1:0] miss_total;
      logic [CNT_W-1:0] evict_total;
      logic             last;
   } rsp_type;

   // One memory row holds the tags and recency ranks of all ways of a set.
   typedef struct packed {
      logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
      logic [MAX_WAYS-1:0][AGE_W-1:0] age;
   } row_type;

   typedef struct packed {
      logic busy;
      logic lookup;
      logic second;
      logic last;
   } ctrl_type;

endpackage

// ----- hw/rtl/sactl_tag_ram.sv -----
// Set-indexed row memory holding the tags and recency ranks of each set.
// One write port, one read port with a registered read. Uses sactl_pkg.
module sactl_tag_ram (
   input  logic                    clock,
   input  logic                    we,
   input  logic [sactl_pkg::SET_W-1:0] waddr,
   input  sactl_pkg::row_type      wdata,
   input  logic                    re,
   input  logic [sactl_pkg::SET_W-1:0] raddr,
   output sactl_pkg::row_type      rdata
);
   import sactl_pkg::*;

   row_type mem [NUM_SETS];
   row_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/sactl_lookup.sv -----
// Way logic for one set: tag match, fill or LRU victim choice, and age update.
// Purely combinational; the caller registers the row it returns. Uses sactl_pkg.
module sactl_lookup (
   input  sactl_pkg::row_type                row_in,
   input  logic [sactl_pkg::MAX_WAYS-1:0]   valid_in,
   input  logic [sactl_pkg::TAG_W-1:0]      tag,
   input  logic [sactl_pkg::NW_W-1:0]       nw,
   output sactl_pkg::row_type                row_out,
   output logic [sactl_pkg::MAX_WAYS-1:0]   valid_out,
   output logic [1:0]                        outcome
);
   import sactl_pkg::*;

   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] hit_vec;
   logic [MAX_WAYS-1:0] empty_vec;
   logic                hit_any;
   logic                empty_any;
   logic [WAY_W-1:0]    hit_w;
   logic [WAY_W-1:0]    empty_w;
   logic [WAY_W-1:0]    victim_w;
   logic [AGE_W-1:0]    best_age;
   logic                found;
   logic [WAY_W-1:0]    way;
   logic [NW_W-1:0]     old_rank;

   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         in_use[i]    = NW_W'(i) < nw;
         hit_vec[i]   = in_use[i] && valid_in[i] && (row_in.tag[i] == tag);
         empty_vec[i] = in_use[i] && !valid_in[i];
      end
   end

   // Lowest-numbered matching line and lowest-numbered empty line.
   always_comb begin
      hit_any   = 1'b0;
      empty_any = 1'b0;
      hit_w     = '0;
      empty_w   = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_any = 1'b1;
            hit_w   = WAY_W'(i);
         end
         if (empty_vec[i]) begin
            empty_any = 1'b1;
            empty_w   = WAY_W'(i);
         end
      end
   end

   // Oldest line in use; a tie goes to the lowest-numbered one.
   always_comb begin
      found    = 1'b0;
      best_age = '0;
      victim_w = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (in_use[i] && (!found || row_in.age[i] > best_age)) begin
            found    = 1'b1;
            best_age = row_in.age[i];
            victim_w = WAY_W'(i);
         end
      end
   end

   always_comb begin
      if (hit_any) begin
         way      = hit_w;
         old_rank = NW_W'(row_in.age[hit_w]);
         outcome  = OUT_HIT;
      end else if (empty_any) begin
         way      = empty_w;
         old_rank = NW_W'(MAX_WAYS);
         outcome  = OUT_MISS;
      end else begin
         way      = victim_w;
         old_rank = NW_W'(MAX_WAYS);
         outcome  = OUT_EVICT;
      end
   end

   // Lines that were more recent than the touched one move back one rank.
   always_comb begin
      row_out   = row_in;
      valid_out = valid_in;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (in_use[i] && (WAY_W'(i) != way) && valid_in[i]
             && (NW_W'(row_in.age[i]) < old_rank) && (row_in.age[i] < AGE_MAX)) begin
            row_out.age[i] = row_in.age[i] + AGE_W'(1);
         end
      end
      row_out.age[way] = '0;
      row_out.tag[way] = tag;
      valid_out[way]   = 1'b1;
   end

endmodule

// ----- hw/rtl/set_assoc_cache_tag_lru.sv -----
// Top level of the set-associative cache tag store with true LRU replacement.
// Instantiates sactl_tag_ram and sactl_lookup; uses sactl_pkg.
//
//   Channel   Ports                                   Transfer condition
//   request   start, busy, req_payload                start high and busy low
//   response  rsp_valid, rsp_payload                  rsp_valid high (one cycle)
//   config    csr_we, csr_index, csr_wdata            csr_we high
//
// In a load or store transaction the accept cycle reads the set's row from the tag
// memory, and the next cycle compares, updates and writes it back and registers the
// result. In a modify transaction the second lookup works on the row just computed,
// forwarded from a register, so the memory is not read again. Instruction fetches
// are accepted with no result. Reset is synchronous and clears the valid bits, the
// counters and the configuration to its defaults; tag and age contents need no
// clearing. The receiver cannot stall, so the response is registered in the cycle
// after each lookup and is never held.
module set_assoc_cache_tag_lru (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  sactl_pkg::req_type                 req_payload,
   output logic                               rsp_valid,
   output sactl_pkg::rsp_type                 rsp_payload,
   input  logic                               csr_we,
   input  logic [sactl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sactl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sactl_pkg::*;

   // Configuration registers.
   logic [SETB_W-1:0] set_bits_ff;
   logic [WAYS_W-1:0] ways_ff;
   logic [BLKB_W-1:0] block_bits_ff;

   // Control state.
   state_type state_ff;
   state_type state_in;
   ctrl_type  ctrl;
   logic      accept;
   logic      modify_ff;

   // Transaction being looked up.
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;

   // Address split.
   logic [SETB_W-1:0] s_eff;
   logic [ADDR_W-1:0] blk;
   logic [SET_W:0]    set_mask_wide;
   logic [SET_W-1:0]  req_set;
   logic [TAG_W-1:0]  req_tag;
   logic [NW_W-1:0]   nw;

   // Set data.
   logic [MAX_WAYS-1:0] valid_ff [NUM_SETS];
   row_type             ram_rdata;
   row_type             fwd_row_ff;
   row_type             look_row;
   row_type             new_row;
   logic [MAX_WAYS-1:0] new_valid;
   logic [1:0]          outcome;

   // Counters and the response register.
   logic [CNT_W-1:0] hits_ff;
   logic [CNT_W-1:0] misses_ff;
   logic [CNT_W-1:0] evicts_ff;
   logic [CNT_W-1:0] hits_in;
   logic [CNT_W-1:0] misses_in;
   logic [CNT_W-1:0] evicts_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   assign accept = start && !ctrl.busy;
   assign busy   = ctrl.busy;

   // Configuration writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= SETB_W'(4);
         ways_ff       <= WAYS_W'(4);
         block_bits_ff <= BLKB_W'(4);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_wdata[SETB_W-1:0];
            CSR_WAYS:       ways_ff       <= csr_wdata[WAYS_W-1:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata[BLKB_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective configuration. A tag shifted past the top of the address
   // naturally becomes zero, which covers the wide-split case.
   always_comb begin
      if (set_bits_ff > SETB_W'(MAX_SET_BITS)) begin
         s_eff = SETB_W'(MAX_SET_BITS);
      end else begin
         s_eff = set_bits_ff;
      end
      if (ways_ff == '0) begin
         nw = NW_W'(1);
      end else if (ways_ff > WAYS_W'(MAX_WAYS)) begin
         nw = NW_W'(MAX_WAYS);
      end else begin
         nw = NW_W'(ways_ff);
      end
      blk           = req_payload.address >> block_bits_ff;
      set_mask_wide = ((SET_W + 1)'(1) << s_eff) - (SET_W + 1)'(1);
      req_set       = blk[SET_W-1:0] & set_mask_wide[SET_W-1:0];
      req_tag       = blk >> s_eff;
   end

   // Next state.
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_payload.op != OP_IFETCH)) begin
               state_in = ST_LOOKUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOKUP: begin
            if (modify_ff) begin
               state_in = ST_LOOKUP2;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOKUP2: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      case (state_ff)
         ST_IDLE:    ctrl = '{busy: 1'b0, lookup: 1'b0, second: 1'b0, last: 1'b0};
         ST_LOOKUP:  ctrl = '{busy: 1'b1, lookup: 1'b1, second: 1'b0, last: !modify_ff};
         ST_LOOKUP2: ctrl = '{busy: 1'b1, lookup: 1'b1, second: 1'b1, last: 1'b1};
         default:    ctrl = '{busy: 1'b1, lookup: 1'b0, second: 1'b0, last: 1'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         modify_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            modify_ff <= (req_payload.op == OP_MODIFY);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= req_set;
         tag_ff <= req_tag;
      end
   end

   sactl_tag_ram u_tag_ram (
      .clock (clock),
      .we    (ctrl.lookup),
      .waddr (set_ff),
      .wdata (new_row),
      .re    (accept),
      .raddr (req_set),
      .rdata (ram_rdata)
   );

   // The second lookup of a modify uses the row written back in the previous cycle.
   assign look_row = ctrl.second ? fwd_row_ff : ram_rdata;

   sactl_lookup u_lookup (
      .row_in    (look_row),
      .valid_in  (valid_ff[set_ff]),
      .tag       (tag_ff),
      .nw        (nw),
      .row_out   (new_row),
      .valid_out (new_valid),
      .outcome   (outcome)
   );

   always_ff @(posedge clock) begin
      if (ctrl.lookup) begin
         fwd_row_ff <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SETS; i++) begin
            valid_ff[i] <= '0;
         end
      end else if (ctrl.lookup) begin
         valid_ff[set_ff] <= new_valid;
      end
   end

   // Saturating totals, reported including the current lookup.
   always_comb begin
      hits_in   = hits_ff;
      misses_in = misses_ff;
      evicts_in = evicts_ff;
      if (outcome == OUT_HIT) begin
         if (hits_ff != '1) begin
            hits_in = hits_ff + CNT_W'(1);
         end
      end else begin
         if (misses_ff != '1) begin
            misses_in = misses_ff + CNT_W'(1);
         end
         if ((outcome == OUT_EVICT) && (evicts_ff != '1)) begin
            evicts_in = evicts_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.lookup;
         if (ctrl.lookup) begin
            hits_ff   <= hits_in;
            misses_ff <= misses_in;
            evicts_ff <= evicts_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.lookup) begin
         rsp_ff.outcome     <= outcome;
         rsp_ff.hit_total   <= hits_in;
         rsp_ff.miss_total  <= misses_in;
         rsp_ff.evict_total <= evicts_in;
         rsp_ff.last        <= ctrl.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the set-associative cache tag store with LRU replacement.
// Predicts every lookup result in place and compares it with the block's responses.
// Depends on sactl_pkg and set_assoc_cache_tag_lru from hw/rtl.
module testbench;
   import sactl_pkg::*;

   localparam int NUM_LINES     = NUM_SETS * MAX_WAYS;
   // A modify transaction is the longest piece of work; the settling time follows
   // the last owed result, before a register write.
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 250;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   rsp_type               rsp_payload;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SET_BITS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   set_assoc_cache_tag_lru u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the tag store. Lines are indexed set * MAX_WAYS + way, the
   // age is the recency rank with 0 the most recently touched line.
   logic             line_present [NUM_LINES];
   logic [TAG_W-1:0] line_tag     [NUM_LINES];
   logic [AGE_W-1:0] line_rank    [NUM_LINES];
   logic [CNT_W-1:0] hit_tally;
   logic [CNT_W-1:0] miss_count;
   logic [CNT_W-1:0] evict_count;
   logic [SETB_W-1:0] cfg_set_bits;
   logic [WAYS_W-1:0] cfg_ways;
   logic [BLKB_W-1:0] cfg_block_bits;

   // Results still owed by the block, oldest first.
   rsp_type          owed_results [$];
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;

   // Address pools for the random traffic: a handful of tags and sets per phase
   // so that sets fill up, hit and evict instead of missing forever.
   logic [63:0]      tag_pool [6];
   logic [63:0]      set_pool [4];

   function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] value);
      return (value == '1) ? value : value + 1'b1;
   endfunction

   // Makes way w of the set the most recent line. Every other valid line in use
   // that was younger than the touched line gets one step older, saturating.
   // A freshly filled line passes MAX_WAYS as its old rank, i.e. older than all.
   function automatic void promote_line(int unsigned base, int unsigned nw,
                                        int unsigned w, int unsigned old_rank);
      for (int unsigned i = 0; i < nw; i++) begin
         if (i != w && line_present[base + i] && line_rank[base + i] < old_rank &&
             line_rank[base + i] < AGE_MAX) begin
            line_rank[base + i] = line_rank[base + i] + 1'b1;
         end
      end
      line_rank[base + w] = '0;
   endfunction

   // One lookup: splits the address, searches the ways in use, fills the
   // lowest empty way on a miss, or else replaces the oldest way (lowest index
   // on a tie). Returns the outcome code and updates the running totals.
   function automatic logic [1:0] cache_lookup(logic [ADDR_W-1:0] address);
      int unsigned sb;
      int unsigned nw;
      int unsigned base;
      int unsigned victim;
      logic [63:0] blk;
      logic [63:0] tag;
      sb   = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
      nw   = (cfg_ways == 0) ? 1 : (cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways;
      blk  = address >> cfg_block_bits;
      // When block and set bits together cover the whole address, nothing is
      // left above them and the tag comes out as zero by itself.
      tag  = blk >> sb;
      base = int'(blk & ((64'd1 << sb) - 1)) * MAX_WAYS;
      for (int unsigned i = 0; i < nw; i++) begin
         if (line_present[base + i] && line_tag[base + i] == tag) begin
            promote_line(base, nw, i, line_rank[base + i]);
            hit_tally = bump(hit_tally);
            return OUT_HIT;
         end
      end
      for (int unsigned i = 0; i < nw; i++) begin
         if (!line_present[base + i]) begin
            line_present[base + i] = 1'b1;
            line_tag[base + i]     = tag;
            promote_line(base, nw, i, MAX_WAYS);
            miss_count = bump(miss_count);
            return OUT_MISS;
         end
      end
      victim = 0;
      for (int unsigned i = 1; i < nw; i++) begin
         if (line_rank[base + i] > line_rank[base + victim]) victim = i;
      end
      line_tag[base + victim] = tag;
      promote_line(base, nw, victim, MAX_WAYS);
      miss_count  = bump(miss_count);
      evict_count = bump(evict_count);
      return OUT_EVICT;
   endfunction

   // Offers one transaction and waits for the edge that accepts it; start stays
   // high so that a following transaction can go out without a bubble. The
   // predicted results are queued at the accepting edge.
   task automatic send_access(logic [1:0] op, logic [ADDR_W-1:0] address);
      rsp_type result;
      start               <= 1'b1;
      req_payload.op      <= op;
      req_payload.address <= address;
      do @(posedge clock); while (busy);
      if (op != OP_IFETCH) begin
         result.outcome     = cache_lookup(address);
         result.hit_total   = hit_tally;
         result.miss_total  = miss_count;
         result.evict_total = evict_count;
         result.last        = (op != OP_MODIFY);
         owed_results.push_back(result);
         // A modify is a load then a store to the same line.
         if (op == OP_MODIFY) begin
            result.outcome     = cache_lookup(address);
            result.hit_total   = hit_tally;
            result.miss_total  = miss_count;
            result.evict_total = evict_count;
            result.last        = 1'b1;
            owed_results.push_back(result);
         end
      end
   endtask

   // Holds the sender off until every owed result has come back, then lets the
   // block settle so that it is idle for a register write.
   task automatic wait_idle();
      start <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers, one per cycle. The set and way registers are
   // three bits wide, so the unused upper bits of the write data get junk.
   task automatic write_config(logic [SETB_W-1:0] set_bits_val,
                               logic [WAYS_W-1:0] ways_val,
                               logic [BLKB_W-1:0] block_bits_val);
      logic [CSR_IDX_W-1:0]  index_list [3];
      logic [CSR_DATA_W-1:0] data_list  [3];
      index_list[0] = CSR_SET_BITS;
      index_list[1] = CSR_WAYS;
      index_list[2] = CSR_BLOCK_BITS;
      data_list[0]  = {3'($urandom), set_bits_val};
      data_list[1]  = {3'($urandom), ways_val};
      data_list[2]  = block_bits_val;
      for (int i = 0; i < 3; i++) begin
         csr_we    <= 1'b1;
         csr_index <= index_list[i];
         csr_wdata <= data_list[i];
         @(posedge clock);
         case (index_list[i])
            CSR_SET_BITS:   cfg_set_bits   = data_list[i][SETB_W-1:0];
            CSR_WAYS:       cfg_ways       = data_list[i][WAYS_W-1:0];
            CSR_BLOCK_BITS: cfg_block_bits = data_list[i][BLKB_W-1:0];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // Address for the reset configuration: 4 offset bits, 4 set bits.
   function automatic logic [ADDR_W-1:0] default_address(logic [63:0] tag,
                                                         logic [3:0] set);
      return (tag << 8) | (64'(set) << 4);
   endfunction

   // Random address: mostly a pooled tag and set under the current split with a
   // random byte offset, and now and then a completely random address.
   function automatic logic [ADDR_W-1:0] random_address();
      int unsigned sb;
      int unsigned bb;
      logic [63:0] offset;
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      sb     = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
      bb     = cfg_block_bits;
      offset = {$urandom, $urandom} & ((64'd1 << bb) - 1);
      return (tag_pool[$urandom_range(0, 5)] << (bb + sb)) |
             ((set_pool[$urandom_range(0, 3)] & ((64'd1 << sb) - 1)) << bb) | offset;
   endfunction

   // Reset configuration: fills one set, evicts in LRU order, and covers every
   // access kind along with the all-zero and all-one addresses.
   task automatic test_reset_config();
      send_access(OP_LOAD,   default_address(1, 0));
      send_access(OP_STORE,  default_address(2, 0));
      send_access(OP_LOAD,   default_address(3, 0));
      send_access(OP_MODIFY, default_address(4, 0));   // miss then hit
      send_access(OP_LOAD,   default_address(1, 0));   // hit, tag 2 is now oldest
      send_access(OP_LOAD,   default_address(5, 0));   // evicts tag 2
      send_access(OP_IFETCH, default_address(2, 0));   // no result, no change
      send_access(OP_LOAD,   default_address(2, 0));   // evicts tag 3
      send_access(OP_STORE,  64'd0);
      send_access(OP_LOAD,   '1);
      send_access(OP_MODIFY, '1);
      send_access(OP_LOAD,   64'hFFFF_FFFF_FFFF_FF00 | 64'h0F);
   endtask

   // Narrowest split: no offset and no set bits, a single way in use.
   task automatic test_narrow_split();
      wait_idle();
      write_config(3'd0, 3'd1, 6'd0);
      send_access(OP_LOAD,   64'd0);
      send_access(OP_LOAD,   64'd1);
      send_access(OP_LOAD,   64'd1);
      send_access(OP_MODIFY, 64'd2);
   endtask

   // Widest split: set bits above the maximum are clipped, a way count of zero
   // acts as one, and a 63-bit offset leaves the tag at zero.
   task automatic test_wide_split();
      wait_idle();
      write_config(3'd7, 3'd0, 6'd63);
      send_access(OP_LOAD,   '1);
      send_access(OP_STORE,  64'd0);
      send_access(OP_MODIFY, 64'h8000_0000_0000_0000);
      send_access(OP_IFETCH, 64'd5);
   endtask

   // A way count above the maximum acts as the maximum; the set comes from the
   // top six address bits, and lines filled earlier come back into use.
   task automatic test_ways_over_range();
      wait_idle();
      write_config(3'd6, 3'd7, 6'd58);
      send_access(OP_LOAD,  64'hFC00_0000_0000_0000);
      send_access(OP_STORE, 64'h0400_0000_0000_0000);
      send_access(OP_LOAD,  64'd0);
      send_access(OP_LOAD,  64'h03FF_FFFF_FFFF_FFFF);
   endtask

   // Random traffic in phases of differing configuration. The sender works in
   // bursts with random gaps, except in one phase that runs back to back. Every
   // phase starts by draining all results, so the sender also pauses at least
   // once until nothing is owed.
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned burst_left;
      logic [1:0]  op;
      for (int phase = 0; phase < 7; phase++) begin
         wait_idle();
         case (phase)
            0: write_config(3'd3, 3'd2, 6'd6);
            1: write_config(3'd0, 3'd1, 6'd0);
            2: write_config(3'd7, 3'd7, 6'd63);
            3: write_config(3'd6, 3'd4, 6'd0);
            4: write_config(3'd2, 3'd0, 6'd61);
            5: write_config(3'd5, 3'd3, 6'd12);
            default: write_config(3'($urandom), 3'($urandom), 6'($urandom));
         endcase
         for (int i = 0; i < 6; i++) begin
            tag_pool[i] = (i < 3) ? 64'($urandom_range(0, 15)) : {$urandom, $urandom};
         end
         for (int i = 0; i < 4; i++) set_pool[i] = 64'($urandom_range(0, 63));
         sent       = 0;
         burst_left = $urandom_range(1, 16);
         while (sent < PHASE_ITEMS) begin
            if (burst_left == 0) begin
               if (phase != 3) begin
                  start <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(posedge clock);
               end
               burst_left = $urandom_range(1, 16);
            end
            op = 2'($urandom_range(0, 3));
            send_access(op, random_address());
            sent++;
            burst_left--;
         end
      end
   endtask

   function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                       logic [CNT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Each response is sampled at the edge that ends its cycle and matched
   // against the oldest owed result.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, rsp_payload);
            error_count++;
         end else begin
            want = owed_results.pop_front();
            check_field("outcome",     CNT_W'(want.outcome), CNT_W'(rsp_payload.outcome));
            check_field("hit_total",   want.hit_total,       rsp_payload.hit_total);
            check_field("miss_total",  want.miss_total,      rsp_payload.miss_total);
            check_field("evict_total", want.evict_total,     rsp_payload.evict_total);
            check_field("last",        CNT_W'(want.last),    CNT_W'(rsp_payload.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      // The shadow store starts as the block comes out of reset.
      for (int i = 0; i < NUM_LINES; i++) begin
         line_present[i] = 1'b0;
         line_tag[i]     = '0;
         line_rank[i]    = '0;
      end
      hit_tally      = '0;
      miss_count     = '0;
      evict_count    = '0;
      cfg_set_bits   = 3'd4;
      cfg_ways       = 3'd4;
      cfg_block_bits = 6'd4;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_config();
      test_narrow_split();
      test_wide_split();
      test_ways_over_range();
      test_random_traffic();

      wait_idle();
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
